FILE: sv/wsm_pkg.sv
// wsm_pkg: shared types, opcodes and sizes for the word stack machine
// no dependencies
`timescale 1ns / 1ps
package wsm_pkg;
  localparam int STACK_DEPTH  = 1024;
  localparam int MEMORY_BYTES = 512;
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int MA_W   = $clog2(MEMORY_BYTES);
  localparam int WORD_BYTES = 32;
  localparam int WIU_W  = 5;
  localparam logic [WIU_W-1:0] WORDS_AT_RESET = WIU_W'(4);

  localparam logic [3:0] OP_PUSH   = 4'd0;
  localparam logic [3:0] OP_POP    = 4'd1;
  localparam logic [3:0] OP_DUP    = 4'd2;
  localparam logic [3:0] OP_SWAP   = 4'd3;
  localparam logic [3:0] OP_ISZERO = 4'd4;
  localparam logic [3:0] OP_LT     = 4'd5;
  localparam logic [3:0] OP_ADD    = 4'd6;
  localparam logic [3:0] OP_MUL    = 4'd7;
  localparam logic [3:0] OP_SUB    = 4'd8;
  localparam logic [3:0] OP_SDIV   = 4'd9;
  localparam logic [3:0] OP_MSTORE = 4'd10;
  localparam logic [3:0] OP_MLOAD  = 4'd11;
  localparam logic [3:0] OP_MSIZE  = 4'd12;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] push_value;
    logic [10:0] depth_index;
  } instr_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [10:0] stack_depth;
    logic        underflow;
    logic        overflow;
    logic        bad_index;
    logic        bad_address;
  } result_t;
endpackage

FILE: sv/wsm_if.sv
// wsm_if: valid/ready channel carrying a payload of type T
// no dependencies; the payload type is given as the parameter T
`timescale 1ns / 1ps
interface wsm_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/word_stack_machine_with_byte_memory.sv
// word_stack_machine_with_byte_memory: top level of the word stack machine
// depends on wsm_pkg, wsm_if, wsm_front, wsm_back
//
//  channel   dir  payload
//  in_ch     in   func, push_value, depth_index
//  out_ch    out  result_value, stack_depth, underflow, overflow,
//                 bad_index, bad_address
//
// with out_ch ready an item steps through idle, the two stack reads and
// exec; pop and a flagged dup or swap go on to the top read, mstore first
// writes its byte, the rest write a result, mul adds S_MUL, sdiv waits on
// the bit-serial divider, and a valid swap adds S_SWP for the single port
// after reset the byte memory is cleared one byte a cycle, all 512 bytes,
// during which the back takes no item and the queue holds at most two
// a two-entry queue lets the front keep taking items while the back works
// or waits on out_ch ready
`timescale 1ns / 1ps
module word_stack_machine_with_byte_memory import wsm_pkg::*; (
  input  logic clk,
  input  logic rst,
  wsm_if.sink   in_ch,
  wsm_if.source out_ch
);
  logic   q_valid, q_pop;
  instr_t q_data;

  wsm_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

  wsm_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule

FILE: sv/wsm_ram.sv
// wsm_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module wsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: sv/wsm_front.sv
// wsm_front: accepts instructions into a two-entry queue
// depends on wsm_pkg
`timescale 1ns / 1ps
module wsm_front import wsm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  instr_t in_data,
  output logic   q_valid,
  input  logic   q_pop,
  output instr_t q_data
);
  instr_t      slot [2];
  logic        rd_ptr, wr_ptr;
  logic [1:0]  fill;
  logic        push;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_data;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: sv/wsm_div.sv
// wsm_div: iterative signed 32-bit divider, one quotient bit per cycle
// depends on wsm_pkg
`timescale 1ns / 1ps
module wsm_div import wsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem, quo, dsr;
  logic [5:0]  cnt;
  logic        neg, busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= dividend[31] ? (32'd0 - dividend) : dividend;
        dsr  <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg  <= dividend[31] ^ divisor[31];
        if (divisor == 32'd0) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= '0;
        end
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? (32'd0 - {quo[30:0], ~trial[32]})
                          : {quo[30:0], ~trial[32]};
        end
      end
    end
  end
endmodule

FILE: sv/wsm_back.sv
// wsm_back: sequencer that executes one instruction on stack and memory
// depends on wsm_pkg, wsm_ram, wsm_div
`timescale 1ns / 1ps
module wsm_back import wsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_pop,
  input  instr_t  q_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MRD   = 4'd7;
  localparam logic [3:0] S_SWP   = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_TOP   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]       state;
  instr_t           ins;
  logic [CNT_W-1:0] count;
  logic [WIU_W-1:0] words_in_use;
  logic [31:0]      a, b, res, top;
  logic             uf, ov, bi, ba, popped;
  logic [MA_W-1:0]  clr_addr;

  // stack ram port
  logic             s_we;
  logic [SP_W-1:0]  s_addr;
  logic [31:0]      s_wdata, s_rdata;
  // byte ram port
  logic             m_we;
  logic [MA_W-1:0]  m_addr;
  logic [7:0]       m_wdata, m_rdata;

  logic             div_start, div_done, div_go;
  logic [31:0]      div_q;
  logic [31:0]      prod;

  // operand count pops per op
  logic [1:0]       npop;
  always_comb begin
    case (ins.func)
      OP_POP, OP_ISZERO, OP_MLOAD: npop = 2'd1;
      OP_LT, OP_ADD, OP_MUL, OP_SUB, OP_SDIV, OP_MSTORE: npop = 2'd2;
      default: npop = 2'd0;
    endcase
  end

  wsm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
  wsm_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_bytes (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
  wsm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a), .divisor(b),
    .done(div_done), .quotient(div_q));

  // pending stack write (result push or swap) description
  logic             wr_en;
  logic [SP_W-1:0]  wr_addr;
  logic [31:0]      wr_data;
  logic [SP_W-1:0]  swp_lo;

  assign prod = a * b;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);
  assign div_start = (state == S_DIV) && div_go;

  always_comb begin
    s_we    = 1'b0;
    s_addr  = count[SP_W-1:0] - SP_W'(1);
    s_wdata = wr_data;
    m_we    = 1'b0;
    m_addr  = a[MA_W-1:0];
    m_wdata = b[7:0];
    case (state)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_addr  = clr_addr;
        m_wdata = 8'd0;
      end
      S_RDA: s_addr = count[SP_W-1:0] - SP_W'(1);
      S_RDB: s_addr = count[SP_W-1:0] - SP_W'(2);
      S_EXEC: begin
        if (ins.func == OP_DUP)
          s_addr = count[SP_W-1:0] - ins.depth_index[SP_W-1:0];
        else if (ins.func == OP_SWAP)
          s_addr = swp_lo;
      end
      S_MRD: begin
        if (ins.func == OP_MSTORE && !ba) m_we = 1'b1;
      end
      S_WR: begin
        s_we   = wr_en;
        s_addr = wr_addr;
      end
      S_SWP: begin
        s_we    = 1'b1;
        s_addr  = swp_lo;
        s_wdata = top;
      end
      S_TOP: s_addr = count[SP_W-1:0] - SP_W'(1);
      default: ;
    endcase
  end

  assign swp_lo = count[SP_W-1:0] - SP_W'(1) - ins.depth_index[SP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      count        <= '0;
      words_in_use <= WORDS_AT_RESET;
      div_go       <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MA_W'(1);
          if (clr_addr == MA_W'(MEMORY_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          ins <= q_data;
          uf <= 1'b0; ov <= 1'b0; bi <= 1'b0; ba <= 1'b0;
          popped <= 1'b0; wr_en <= 1'b0;
          a <= '0; b <= '0;
          state <= S_RDA;
        end
        S_RDA: begin
          // read of top issued now
          state <= S_RDB;
          top <= '0;
        end
        S_RDB: begin
          top <= s_rdata;
          if (npop != 2'd0) begin
            if (count == '0) begin
              uf <= 1'b1;
              a  <= '0;
            end else begin
              a <= s_rdata;
            end
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          // previous cycle (RDB) read next-of-stack
          div_go <= (ins.func == OP_SDIV);
          if (npop == 2'd2) begin
            if (count >= CNT_W'(2)) b <= s_rdata;
            else begin
              b  <= '0;
              uf <= 1'b1;
            end
            if (count >= CNT_W'(2)) count <= count - CNT_W'(2);
            else count <= '0;
          end else if (npop == 2'd1) begin
            if (count != '0) count <= count - CNT_W'(1);
          end
          if (ins.func == OP_MSTORE || ins.func == OP_MLOAD) begin
            if (a >= 32'(MEMORY_BYTES)) ba <= 1'b1;
          end
          case (ins.func)
            OP_POP: begin
              res <= a; popped <= 1'b1; state <= S_TOP;
            end
            OP_PUSH: begin
              wr_data <= ins.push_value; state <= S_MRD;
            end
            OP_DUP: begin
              if (ins.depth_index == '0 || 11'(ins.depth_index) > 11'(count)) begin
                bi <= 1'b1; state <= S_TOP;
              end else state <= S_MRD;
            end
            OP_SWAP: begin
              if (11'(ins.depth_index) >= 11'(count)) begin
                bi <= 1'b1; state <= S_TOP;
              end else state <= S_MRD;
            end
            OP_MUL: state <= S_MUL;
            OP_SDIV: state <= S_DIV;
            OP_MSTORE: state <= S_MRD;
            OP_MLOAD: state <= S_MRD;
            OP_ISZERO, OP_LT, OP_ADD, OP_SUB, OP_MSIZE: state <= S_MRD;
            default: state <= S_TOP;
          endcase
        end
        S_MUL: begin
          wr_data <= prod;
          state   <= S_MRD;
        end
        S_DIV: begin
          // divider started on the first cycle here, operands now settled
          div_go <= 1'b0;
          if (div_done) begin
            wr_data <= div_q;
            state   <= S_MRD;
          end
        end
        S_MRD: begin
          // ram read data for dup, swap, mload arrives here
          wr_addr <= count[SP_W-1:0];
          wr_en   <= 1'b0;
          state   <= S_WR;
          case (ins.func)
            OP_ISZERO: wr_data <= (a == '0) ? 32'd1 : 32'd0;
            OP_LT:     wr_data <= ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            OP_ADD:    wr_data <= a + b;
            OP_SUB:    wr_data <= a - b;
            OP_DUP:    wr_data <= s_rdata;
            OP_SWAP: begin
              wr_data <= s_rdata;
              wr_addr <= count[SP_W-1:0] - SP_W'(1);
              wr_en   <= 1'b1;
            end
            OP_MLOAD:  wr_data <= ba ? 32'd0 : {24'd0, m_rdata};
            OP_MSIZE:  wr_data <= 32'(words_in_use) * 32'(WORD_BYTES);
            OP_MSTORE: begin
              if (!ba && (WIU_W'(a[MA_W-1:5]) + WIU_W'(1)) > words_in_use)
                words_in_use <= WIU_W'(a[MA_W-1:5]) + WIU_W'(1);
              state <= S_TOP;
            end
            default: ;
          endcase
          if (ins.func != OP_SWAP && ins.func != OP_MSTORE) begin
            if (count == CNT_W'(STACK_DEPTH)) ov <= 1'b1;
            else begin
              wr_en <= 1'b1;
              count <= count + CNT_W'(1);
            end
          end
        end
        S_WR: begin
          if (ins.func == OP_SWAP) state <= S_SWP;
          else state <= S_TOP;
        end
        S_SWP: state <= S_TOP;
        S_TOP: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // top word was read in S_TOP and the stack address holds while in S_OUT
  assign out_data.result_value = popped ? res
                                 : ((count == '0) ? 32'd0 : s_rdata);
  assign out_data.stack_depth  = 11'(count);
  assign out_data.underflow    = uf;
  assign out_data.overflow     = ov;
  assign out_data.bad_index    = bi;
  assign out_data.bad_address  = ba;
endmodule

FILE: tb/sv/tb_word_stack_machine_with_byte_memory.sv
// tb_word_stack_machine_with_byte_memory: self-checking bench for the word stack machine
// depends on wsm_pkg, wsm_if and the rtl top level
`timescale 1ns / 1ps
module tb_word_stack_machine_with_byte_memory;
  import wsm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wsm_if #(.T(instr_t))  in_ch  (.clk(clk));
  wsm_if #(.T(result_t)) out_ch (.clk(clk));

  word_stack_machine_with_byte_memory dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state, a private copy of the machine
  // ---------------------------------------------------------------------------
  logic [31:0]      mach_stack [STACK_DEPTH];
  int unsigned      mach_count;
  logic [7:0]       mach_bytes [MEMORY_BYTES];
  logic [WIU_W-1:0] mach_words_used;
  logic             step_under, step_over;

  result_t     pending_results[$];
  int          fail_count = 0;
  bit          stim_done = 1'b0;
  bit          quiet_phase = 1'b0;
  bit          hold_rx = 1'b0;

  function automatic void mach_push(logic [31:0] w);
    if (mach_count < STACK_DEPTH) begin
      mach_stack[mach_count] = w;
      mach_count++;
    end else begin
      step_over = 1'b1;
    end
  endfunction

  function automatic logic [31:0] mach_pop();
    if (mach_count == 0) begin
      step_under = 1'b1;
      return 32'd0;
    end
    mach_count--;
    return mach_stack[mach_count];
  endfunction

  // signed quotient, truncating toward zero, 0 on a zero divisor
  function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    if (b == 32'd0) return 32'd0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // works out the result of one instruction and advances the private state
  function automatic result_t exec_instr(instr_t ins);
    result_t     r;
    logic [31:0] a, b, t;
    int unsigned top, oth;
    bit popped;
    popped = 1'b0;
    step_under = 1'b0;
    step_over = 1'b0;
    r = '0;
    case (ins.func)
      OP_PUSH: mach_push(ins.push_value);
      OP_POP: begin
        r.result_value = mach_pop();
        popped = 1'b1;
      end
      OP_DUP: begin
        if (ins.depth_index >= 1 && ins.depth_index <= mach_count)
          mach_push(mach_stack[mach_count - ins.depth_index]);
        else
          r.bad_index = 1'b1;
      end
      OP_SWAP: begin
        if (ins.depth_index < mach_count) begin
          top = mach_count - 1;
          oth = top - ins.depth_index;
          t = mach_stack[top];
          mach_stack[top] = mach_stack[oth];
          mach_stack[oth] = t;
        end else begin
          r.bad_index = 1'b1;
        end
      end
      OP_ISZERO: begin
        a = mach_pop();
        mach_push({31'd0, a == 32'd0});
      end
      OP_LT, OP_ADD, OP_MUL, OP_SUB, OP_SDIV: begin
        a = mach_pop();
        b = mach_pop();
        case (ins.func)
          OP_LT:   mach_push({31'd0, $signed(a) < $signed(b)});
          OP_ADD:  mach_push(a + b);
          OP_MUL:  mach_push(a * b);
          OP_SUB:  mach_push(a - b);
          default: mach_push(quot_trunc(a, b));
        endcase
      end
      OP_MSTORE: begin
        a = mach_pop();
        b = mach_pop();
        if (a < MEMORY_BYTES) begin
          if (a / WORD_BYTES + 1 > mach_words_used)
            mach_words_used = WIU_W'(a / WORD_BYTES + 1);
          mach_bytes[a] = b[7:0];
        end else begin
          r.bad_address = 1'b1;
        end
      end
      OP_MLOAD: begin
        a = mach_pop();
        if (a < MEMORY_BYTES) begin
          mach_push({24'd0, mach_bytes[a]});
        end else begin
          r.bad_address = 1'b1;
          mach_push(32'd0);
        end
      end
      OP_MSIZE: mach_push(32'(mach_words_used) * WORD_BYTES);
      default: ;
    endcase
    if (!popped)
      r.result_value = (mach_count > 0) ? mach_stack[mach_count - 1] : 32'd0;
    r.stack_depth = 11'(mach_count);
    r.underflow = step_under;
    r.overflow = step_over;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  int unsigned items_sent = 0;

  // one item, with a random idle burst before it unless the run is in its quiet tail
  task automatic send_instr(instr_t ins);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= ins;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(exec_instr(ins));
    items_sent++;
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic instr_t mk(logic [3:0] f, logic [31:0] v, logic [10:0] d);
    instr_t i;
    i.func = f;
    i.push_value = v;
    i.depth_index = d;
    return i;
  endfunction

  // random operand, biased toward edges and small addresses
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4, 5: return 32'($urandom_range(0, MEMORY_BYTES + 8));
      default: return $urandom;
    endcase
  endfunction

  // random instruction; about a third pushes, the rest other opcodes and, rarely, unused codes 13 to 15
  function automatic instr_t rand_instr();
    logic [3:0] f;
    logic [10:0] d;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) f = OP_PUSH;
    else if (sel < 97) f = 4'($urandom_range(1, 12));
    else f = 4'($urandom_range(13, 15));
    if ($urandom_range(0, 9) == 0) d = 11'($urandom);
    else d = 11'($urandom_range(0, 6));
    return mk(f, rand_word(), d);
  endfunction

  // directed table; expected result only where it is obvious
  typedef struct {
    instr_t  ins;
    bit      has_exp;
    result_t exp;
  } dir_row_t;

  function automatic result_t rs(logic [31:0] v, logic [10:0] n,
                                 bit u, bit o, bit bi, bit ba);
    result_t r;
    r.result_value = v;
    r.stack_depth = n;
    r.underflow = u;
    r.overflow = o;
    r.bad_index = bi;
    r.bad_address = ba;
    return r;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    instr_t ins;
    int n;
    int k;
    // empty-stack cases right after reset, then msize, iszero and two pushes
    dir_rows.push_back('{mk(OP_POP, 0, 0),  1, rs(0, 0, 1, 0, 0, 0)});
    dir_rows.push_back('{mk(OP_DUP, 0, 1),  1, rs(0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mk(OP_SWAP, 0, 0), 1, rs(0, 0, 0, 0, 1, 0)});
    dir_rows.push_back('{mk(OP_MSIZE, 0, 0), 1, rs(128, 1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(OP_ISZERO, 0, 0), 1, rs(0, 1, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(OP_PUSH, 32'h8000_0000, 0), 1, rs(32'h8000_0000, 2, 0, 0, 0, 0)});
    dir_rows.push_back('{mk(OP_PUSH, 32'hffff_ffff, 11'h7ff), 1,
                         rs(32'hffff_ffff, 3, 0, 0, 0, 0)});
    // most negative divided by -1 wraps; swap puts the most negative on top as a
    dir_rows.push_back('{mk(OP_SWAP, 0, 1), 0, '0});
    dir_rows.push_back('{mk(OP_SDIV, 0, 0), 0, '0});
    dir_rows.push_back('{mk(OP_PUSH, 0, 0), 0, '0});
    dir_rows.push_back('{mk(OP_PUSH, 32'h7fff_ffff, 0), 0, '0});
    dir_rows.push_back('{mk(OP_SDIV, 0, 0), 0, '0});        // divide by zero
    dir_rows.push_back('{mk(OP_DUP, 0, 0), 0, '0});         // dup index 0
    dir_rows.push_back('{mk(OP_DUP, 0, 11'd1024), 0, '0});  // dup too deep
    dir_rows.push_back('{mk(OP_PUSH, 32'h1ab, 0), 0, '0});
    dir_rows.push_back('{mk(OP_PUSH, 32'h1ff, 0), 0, '0});
    dir_rows.push_back('{mk(OP_MSTORE, 0, 0), 0, '0});      // last byte of memory
    dir_rows.push_back('{mk(OP_PUSH, 32'h1ff, 0), 0, '0});
    dir_rows.push_back('{mk(OP_MLOAD, 0, 0), 0, '0});
    dir_rows.push_back('{mk(OP_PUSH, 32'h200, 0), 0, '0});
    dir_rows.push_back('{mk(OP_MLOAD, 0, 0), 0, '0});       // just past memory
    dir_rows.push_back('{mk(OP_PUSH, 32'hffff_fff0, 0), 0, '0});
    dir_rows.push_back('{mk(OP_MSTORE, 0, 0), 0, '0});      // negative address
    dir_rows.push_back('{mk(OP_LT, 0, 0), 0, '0});
    dir_rows.push_back('{mk(4'd15, 0, 0), 0, '0});          // unused code

    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_instr(dir_rows[i].ins);
      if (dir_rows[i].has_exp) pending_results[$] = dir_rows[i].exp;
    end
    for (k = 0; k < 8; k++) send_instr(mk(OP_MUL, 0, 0));  // drain into underflow

    // long receiver hold-off while items keep coming, so the input stalls
    hold_rx = 1'b1;
    for (k = 0; k < 6; k++) send_instr(rand_instr());
    drop_valid();
    wait (pending_results.size() == 0);
    // sender pause: everything answered before going on

    for (k = 0; k < 300; k++) send_instr(rand_instr());

    // quiet tail: fill to full, then dup, swap, msize and push at full depth
    quiet_phase = 1'b1;
    n = STACK_DEPTH - int'(mach_count) + 4;
    for (k = 0; k < n; k++) begin
      ins = mk(OP_PUSH, $urandom, 0);
      if (k == n - 4) ins = mk(OP_DUP, 0, 11'd1024);
      if (k == n - 3) ins = mk(OP_SWAP, 0, 11'd1023);
      if (k == n - 2) ins = mk(OP_MSIZE, 0, 0);
      send_instr(ins);
    end
    drop_valid();
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // receiver with random stalls and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.result_value !== want.result_value) begin
          $error("result_value exp %h got %h", want.result_value, got.result_value);
          fail_count++;
        end
        if (got.stack_depth !== want.stack_depth) begin
          $error("stack_depth exp %0d got %0d", want.stack_depth, got.stack_depth);
          fail_count++;
        end
        if (got.underflow !== want.underflow) begin
          $error("underflow exp %b got %b", want.underflow, got.underflow);
          fail_count++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow exp %b got %b", want.overflow, got.overflow);
          fail_count++;
        end
        if (got.bad_index !== want.bad_index) begin
          $error("bad_index exp %b got %b", want.bad_index, got.bad_index);
          fail_count++;
        end
        if (got.bad_address !== want.bad_address) begin
          $error("bad_address exp %b got %b", want.bad_address, got.bad_address);
          fail_count++;
        end
      end
    end
  end

  // end of run: drain, then wait on to catch stray results before the verdict
  initial begin
    for (int k = 0; k < MEMORY_BYTES; k++) mach_bytes[k] = 8'd0;
    mach_count = 0;
    mach_words_used = WORDS_AT_RESET;
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

FILE: sim.f
sv/wsm_pkg.sv
sv/wsm_if.sv
sv/wsm_ram.sv
sv/wsm_front.sv
sv/wsm_div.sv
sv/wsm_back.sv
sv/word_stack_machine_with_byte_memory.sv
tb/sv/tb_word_stack_machine_with_byte_memory.sv
